[rtl/core/acb_pkg.sv]
// ============================================================================
// acb_pkg
// Shared types and status codes for the bulge-to-arc centre and radius block.
// ============================================================================
package acb_pkg;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned RADIUS_W = 32;
    localparam int unsigned STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd2;

    // One input beat: chord end points in millimeters and a Q16.16 bulge.
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] bulge_q16;
    } arc_in_t;

    // One result beat: status, rounded center and radius, turning sense.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic [RADIUS_W-1:0]       radius_mm;
        logic                      counter_clockwise;
    } arc_out_t;

endpackage

[rtl/core/arc_centre_from_bulge.sv]
// ============================================================================
// arc_centre_from_bulge
// Arc center, radius and turning sense from a chord and a Q16.16 bulge.
// ============================================================================
//
//  Channel   Handshake          Payload              Direction
//  -------   ----------------   ------------------   ---------
//  input     start / busy       item   (arc_in_t)    in
//  result    done (strobe)      result (arc_out_t)   out
//
//  A beat is taken at every edge with start high and busy low; busy is only
//  high while reset is applied and for the first cycle after it.
//  One beat can enter every cycle while busy is low. The pipeline ends in
//  the 34-stage restoring divider and square root section, which retires
//  one quotient bit and one root bit per stage.
//  The result receiver cannot stall, so the pipeline never holds.
//
// ============================================================================
module arc_centre_from_bulge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  acb_pkg::arc_in_t  item,
    output logic              done,
    output acb_pkg::arc_out_t result
);

    // Pipeline levels.
    localparam int unsigned MUL_LAT  = 3;
    localparam int unsigned ROOT_BITS = 34;
    localparam int unsigned ST_DIFF  = 0;
    localparam int unsigned ST_SQ    = ST_DIFF + MUL_LAT + 1;
    localparam int unsigned ST_DP    = ST_SQ + MUL_LAT + 1;
    localparam int unsigned ST_NSUM  = ST_DP + 1;
    localparam int unsigned ST_NUM   = ST_NSUM + 1;
    localparam int unsigned ST_G     = ST_DP + MUL_LAT + 1;
    localparam int unsigned ST_ITER  = ST_G + 1;
    localparam int unsigned ST_LAST  = ST_ITER + ROOT_BITS - 1;

    // Datapath widths.
    localparam int unsigned MAG_W = 32;
    localparam int unsigned SQ_W  = 64;
    localparam int unsigned D_W   = 65;
    localparam int unsigned BB_W  = 63;
    localparam int unsigned DP_W  = 128;
    localparam int unsigned N_W   = 96;
    localparam int unsigned GF_W  = 191;
    localparam int unsigned R_W   = 157;
    localparam int unsigned U_W   = 96;

    typedef struct packed {
        logic [31:0]           ax;
        logic [31:0]           ay;
        logic [MAG_W-1:0]      adx;
        logic [MAG_W-1:0]      ady;
        logic                  sdx;
        logic                  sdy;
        logic [31:0]           ub;
        logic                  bneg;
        logic                  ccw;
        logic                  degen;
        logic [D_W-1:0]        d;
        logic [BB_W-1:0]       bb;
        logic [SQ_W-1:0]       pxb;
        logic [SQ_W-1:0]       pyb;
        logic [DP_W-1:0]       dp;
        logic [N_W-1:0]        ex;
        logic [N_W-1:0]        ey;
        logic [N_W-1:0]        nx;
        logic [N_W-1:0]        ny;
        logic [N_W-1:0]        remx;
        logic [N_W-1:0]        remy;
        logic                  rxneg;
        logic                  ryneg;
        logic [ROOT_BITS-1:0]  qx;
        logic [ROOT_BITS-1:0]  qy;
        logic [R_W-1:0]        rr;
        logic [U_W-1:0]        u;
        logic [ROOT_BITS-1:0]  t;
    } stage_t;

    stage_t              stage_reg  [ST_LAST+1];
    stage_t              stage_next [ST_LAST+1];
    logic [ST_LAST:0]    valid_reg;
    logic [ST_LAST:0]    valid_next;
    logic                busy_reg;
    logic                done_reg;
    logic                done_next;
    acb_pkg::arc_out_t   result_reg;
    acb_pkg::arc_out_t   result_next;

    logic [SQ_W-1:0]          bb_m;
    logic [SQ_W-1:0]          pxb_m;
    logic [SQ_W-1:0]          pyb_m;
    logic [SQ_W-1:0]          sqx_m;
    logic [SQ_W-1:0]          sqy_m;
    logic [D_W+BB_W-1:0]      dbb_m;
    logic [MAG_W+BB_W-1:0]    xbb_m;
    logic [MAG_W+BB_W-1:0]    ybb_m;
    logic [DP_W+BB_W-1:0]     dpbb_m;

    // First multiplier bank: bulge squared, chord times bulge, chord squared.
    acb_mul #(.A_WIDTH(32), .B_WIDTH(32)) u_mul_bb (
        .clk (clk), .a (stage_reg[ST_DIFF].ub), .b (stage_reg[ST_DIFF].ub), .p (bb_m)
    );
    acb_mul #(.A_WIDTH(MAG_W), .B_WIDTH(32)) u_mul_pxb (
        .clk (clk), .a (stage_reg[ST_DIFF].adx), .b (stage_reg[ST_DIFF].ub), .p (pxb_m)
    );
    acb_mul #(.A_WIDTH(MAG_W), .B_WIDTH(32)) u_mul_pyb (
        .clk (clk), .a (stage_reg[ST_DIFF].ady), .b (stage_reg[ST_DIFF].ub), .p (pyb_m)
    );
    acb_mul #(.A_WIDTH(MAG_W), .B_WIDTH(MAG_W)) u_mul_sqx (
        .clk (clk), .a (stage_reg[ST_DIFF].adx), .b (stage_reg[ST_DIFF].adx), .p (sqx_m)
    );
    acb_mul #(.A_WIDTH(MAG_W), .B_WIDTH(MAG_W)) u_mul_sqy (
        .clk (clk), .a (stage_reg[ST_DIFF].ady), .b (stage_reg[ST_DIFF].ady), .p (sqy_m)
    );

    // Second bank: squared length and chord components times bulge squared.
    acb_mul #(.A_WIDTH(D_W), .B_WIDTH(BB_W)) u_mul_dbb (
        .clk (clk), .a (stage_reg[ST_SQ].d), .b (stage_reg[ST_SQ].bb), .p (dbb_m)
    );
    acb_mul #(.A_WIDTH(MAG_W), .B_WIDTH(BB_W)) u_mul_xbb (
        .clk (clk), .a (stage_reg[ST_SQ].adx), .b (stage_reg[ST_SQ].bb), .p (xbb_m)
    );
    acb_mul #(.A_WIDTH(MAG_W), .B_WIDTH(BB_W)) u_mul_ybb (
        .clk (clk), .a (stage_reg[ST_SQ].ady), .b (stage_reg[ST_SQ].bb), .p (ybb_m)
    );

    // Third bank: completes D * (1 + b^2)^2.
    acb_mul #(.A_WIDTH(DP_W), .B_WIDTH(BB_W)) u_mul_dpbb (
        .clk (clk), .a (stage_reg[ST_DP].dp), .b (stage_reg[ST_DP].bb), .p (dpbb_m)
    );

    // Per-level datapath.
    always_comb
    begin
        stage_t            s;
        logic [32:0]       dx;
        logic [32:0]       dy;
        logic [N_W-1:0]    px17;
        logic [N_W-1:0]    py17;
        logic [N_W-1:0]    dsh;
        logic [R_W-1:0]    delta;
        logic [GF_W-1:0]   gfull;
        int                j;

        j = 0;
        for (int k = 1; k <= ST_LAST; k++)
        begin
            stage_next[k] = stage_reg[k-1];
        end

        // Chord, magnitudes and signs of the incoming beat.
        s     = '0;
        dx    = {item.end_x[31], item.end_x} - {item.start_x[31], item.start_x};
        dy    = {item.end_y[31], item.end_y} - {item.start_y[31], item.start_y};
        s.ax  = item.start_x;
        s.ay  = item.start_y;
        s.sdx = dx[32];
        s.sdy = dy[32];
        s.adx = dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        s.ady = dy[32] ? 32'(33'd0 - dy) : dy[31:0];
        s.bneg = item.bulge_q16[31];
        s.ub   = item.bulge_q16[31] ? (32'd0 - $unsigned(item.bulge_q16))
                                    : $unsigned(item.bulge_q16);
        s.ccw   = !item.bulge_q16[31] && (item.bulge_q16 != '0);
        s.degen = (item.bulge_q16 == '0) || ((dx == '0) && (dy == '0));
        stage_next[ST_DIFF] = s;

        // Squared chord length and first products.
        stage_next[ST_SQ].d   = D_W'(sqx_m) + D_W'(sqy_m);
        stage_next[ST_SQ].bb  = bb_m[BB_W-1:0];
        stage_next[ST_SQ].pxb = pxb_m;
        stage_next[ST_SQ].pyb = pyb_m;

        // D * (1 + b^2) and the chord terms scaled by (b^2 - 1).
        stage_next[ST_DP].dp = (DP_W'(stage_reg[ST_DP-1].d) << 32) + dbb_m;
        stage_next[ST_DP].ex = N_W'(ybb_m) - (N_W'(stage_reg[ST_DP-1].ady) << 32);
        stage_next[ST_DP].ey = N_W'(xbb_m) - (N_W'(stage_reg[ST_DP-1].adx) << 32);

        // Signed numerators of the two center offsets.
        s    = stage_reg[ST_NSUM-1];
        px17 = N_W'(s.pxb) << 17;
        py17 = N_W'(s.pyb) << 17;
        stage_next[ST_NSUM].nx = ((s.sdx ^ s.bneg) ? (N_W'(0) - px17) : px17)
                               + (s.sdy ? (N_W'(0) - s.ex) : s.ex);
        stage_next[ST_NSUM].ny = ((s.sdy ^ s.bneg) ? (N_W'(0) - py17) : py17)
                               + (s.sdx ? s.ey : (N_W'(0) - s.ey));

        // Magnitudes plus half the divisor, so the quotient rounds to nearest.
        s = stage_reg[ST_NUM-1];
        stage_next[ST_NUM].remx  = (s.nx[N_W-1] ? (N_W'(0) - s.nx) : s.nx)
                                 + (N_W'(s.ub) << 17);
        stage_next[ST_NUM].remy  = (s.ny[N_W-1] ? (N_W'(0) - s.ny) : s.ny)
                                 + (N_W'(s.ub) << 17);
        stage_next[ST_NUM].rxneg = s.nx[N_W-1] ^ s.bneg;
        stage_next[ST_NUM].ryneg = s.ny[N_W-1] ^ s.bneg;
        stage_next[ST_NUM].qx    = '0;
        stage_next[ST_NUM].qy    = '0;

        // Square root operand: D * (1 + b^2)^2, scaled down by 2^34.
        gfull = (GF_W'(stage_reg[ST_G-1].dp) << 32) + dpbb_m;
        stage_next[ST_G].rr = gfull[GF_W-1:34];
        stage_next[ST_G].u  = '0;
        stage_next[ST_G].t  = '0;

        // One quotient bit per divider and one root bit per level.
        for (int k = ST_ITER; k <= ST_LAST; k++)
        begin
            j   = ST_LAST - k;
            s   = stage_reg[k-1];
            dsh = N_W'(s.ub) << (18 + j);
            if (s.remx >= dsh)
            begin
                s.remx  = s.remx - dsh;
                s.qx[j] = 1'b1;
            end
            if (s.remy >= dsh)
            begin
                s.remy  = s.remy - dsh;
                s.qy[j] = 1'b1;
            end
            // Root test: (t + 2^j)^2 * b^2 against the operand, kept as a remainder.
            delta = (R_W'(s.u) << (j + 1)) + (R_W'(s.bb) << (2 * j));
            if (s.rr >= delta)
            begin
                s.rr   = s.rr - delta;
                s.u    = s.u + (U_W'(s.bb) << j);
                s.t[j] = 1'b1;
            end
            stage_next[k] = s;
        end
    end

    // Final center, radius and status.
    always_comb
    begin
        stage_t       f;
        logic [33:0]  ox;
        logic [33:0]  oy;
        logic [34:0]  cx;
        logic [34:0]  cy;
        logic [32:0]  rad;
        logic         cx_ok;
        logic         cy_ok;
        logic         fail;

        f  = stage_reg[ST_LAST];
        ox = {1'b0, f.qx[32:0]};
        oy = {1'b0, f.qy[32:0]};
        if (f.rxneg)
        begin
            ox = 34'd0 - ox;
        end
        if (f.ryneg)
        begin
            oy = 34'd0 - oy;
        end
        cx    = {{3{f.ax[31]}}, f.ax} + {ox[33], ox};
        cy    = {{3{f.ay[31]}}, f.ay} + {oy[33], oy};
        cx_ok = (cx[34:31] == 4'b0000) || (cx[34:31] == 4'b1111);
        cy_ok = (cy[34:31] == 4'b0000) || (cy[34:31] == 4'b1111);
        rad   = 33'(f.t[32:0]) + 33'd1;
        fail  = f.qx[33] || f.qy[33] || !cx_ok || !cy_ok || f.t[33] || (&f.t[32:0]);

        result_next                   = '0;
        result_next.counter_clockwise = f.ccw;
        if (f.degen)
        begin
            result_next.status = acb_pkg::STATUS_DEGENERATE;
        end
        else if (fail)
        begin
            result_next.status = acb_pkg::STATUS_RANGE;
        end
        else
        begin
            result_next.status    = acb_pkg::STATUS_OK;
            result_next.centre_x  = cx[31:0];
            result_next.centre_y  = cy[31:0];
            result_next.radius_mm = rad[32:1];
        end
        done_next = valid_reg[ST_LAST];
    end

    // Valid bits travel down the levels with the data.
    assign valid_next = {valid_reg[ST_LAST-1:0], start & ~busy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
            busy_reg  <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
            busy_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg  <= stage_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted beat comes out a fixed number of cycles later.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(ST_LAST + 2) done)
        else $error("accepted beat did not produce a result");

    // No result appears without a beat accepted at the matching time.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ST_LAST + 2))
        else $error("result without an accepted beat");

    // A failed result carries zero center and radius.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != acb_pkg::STATUS_OK)) |->
        (result.centre_x == '0 && result.centre_y == '0 && result.radius_mm == '0))
        else $error("failed result carries nonzero fields");

    // A found arc has a nonzero radius.
    a_radius_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == acb_pkg::STATUS_OK)) |-> (result.radius_mm != '0))
        else $error("found arc with zero radius");

endmodule

[rtl/core/acb_mul.sv]
// ============================================================================
// acb_mul
// Pipelined unsigned multiplier built from 32x32 partial products.
// Three register stages: partial products, row sums, final sum.
// ============================================================================
module acb_mul #(
    parameter int unsigned A_WIDTH = 32,
    parameter int unsigned B_WIDTH = 32
) (
    input  logic                       clk,
    input  logic [A_WIDTH-1:0]         a,
    input  logic [B_WIDTH-1:0]         b,
    output logic [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int unsigned CHUNK    = 32;
    localparam int unsigned A_CHUNKS = (A_WIDTH + CHUNK - 1) / CHUNK;
    localparam int unsigned B_CHUNKS = (B_WIDTH + CHUNK - 1) / CHUNK;
    localparam int unsigned ROW_W    = CHUNK * (B_CHUNKS + 1);
    localparam int unsigned SUM_W    = CHUNK * (A_CHUNKS + B_CHUNKS);

    logic [A_CHUNKS*CHUNK-1:0] a_ext;
    logic [B_CHUNKS*CHUNK-1:0] b_ext;
    logic [2*CHUNK-1:0]        part_next [A_CHUNKS][B_CHUNKS];
    logic [2*CHUNK-1:0]        part_reg  [A_CHUNKS][B_CHUNKS];
    logic [ROW_W-1:0]          row_next  [A_CHUNKS];
    logic [ROW_W-1:0]          row_reg   [A_CHUNKS];
    logic [SUM_W-1:0]          sum_next;
    logic [SUM_W-1:0]          sum_reg;

    // Split both operands into chunks and form every partial product.
    always_comb
    begin
        a_ext = '0;
        b_ext = '0;
        a_ext[A_WIDTH-1:0] = a;
        b_ext[B_WIDTH-1:0] = b;
        for (int i = 0; i < A_CHUNKS; i++)
        begin
            for (int j = 0; j < B_CHUNKS; j++)
            begin
                part_next[i][j] = a_ext[CHUNK*i +: CHUNK] * b_ext[CHUNK*j +: CHUNK];
            end
        end
    end

    // Each row gathers the partial products of one chunk of a.
    always_comb
    begin
        for (int i = 0; i < A_CHUNKS; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < B_CHUNKS; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(part_reg[i][j]) << (CHUNK * j));
            end
        end
    end

    // The rows are weighted and summed into the full product.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < A_CHUNKS; i++)
        begin
            sum_next = sum_next + (SUM_W'(row_reg[i]) << (CHUNK * i));
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        row_reg  <= row_next;
        sum_reg  <= sum_next;
    end

    assign p = sum_reg[A_WIDTH+B_WIDTH-1:0];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the chord-and-bulge arc center and radius block.
// Every accepted chord beat is predicted exactly in wide integer math and the
// expected result is queued; each done beat is compared field by field in
// order. Directed corner chords come first, then random chords of mixed size.
// ============================================================================
module tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned RANDOM_ITEMS   = 2000;

    // Scoreboard: predicts each chord beat and checks results in order.
    class arc_scoreboard;
        acb_pkg::arc_out_t expected_q[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       status_seen[3];

        function new();
            mismatches = 0;
            checked    = 0;
            status_seen = '{0, 0, 0};
        endfunction

        // rnd((c1*m1 + c2*m2) / (bq*2^18)); returns 0 when the result reaches 2^33.
        function bit centre_offset(input logic signed [255:0] c1,
                                   input logic signed [255:0] m1,
                                   input logic signed [255:0] c2,
                                   input logic signed [255:0] m2,
                                   input logic signed [255:0] bq,
                                   output logic signed [63:0] offset);
            logic signed [255:0] num;
            logic [255:0]        num_mag;
            logic [255:0]        bq_mag;
            logic [255:0]        quo;
            bit                  neg;
            num     = c1 * m1 + c2 * m2;
            neg     = num < 0;
            num_mag = neg ? -num : num;
            bq_mag  = (bq < 0) ? -bq : bq;
            quo     = ((num_mag << 1) + (bq_mag << 18)) / (bq_mag << 19);
            if (quo >= (256'd1 << 33))
                return 1'b0;
            offset = (neg != (bq < 0)) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
            return 1'b1;
        endfunction

        function acb_pkg::arc_out_t predict_arc(input acb_pkg::arc_in_t chord);
            acb_pkg::arc_out_t   res;
            logic signed [255:0] ax, ay, dx, dy, bq, bb, one_minus, scaled_b;
            logic signed [63:0]  ox, oy, cx, cy;
            logic [255:0]        dist_sq, p_term, quo, sq;
            logic [63:0]         root, cand;
            logic [1:0]          status;
            ax = $signed(chord.start_x);
            ay = $signed(chord.start_y);
            dx = $signed(chord.end_x) - ax;
            dy = $signed(chord.end_y) - ay;
            bq = $signed(chord.bulge_q16);
            bb = bq * bq;
            one_minus = (256'sd1 <<< 32) - bb;
            scaled_b  = bq * 256'sd131072;
            res = '0;
            res.counter_clockwise = bq > 0;
            if (bq == 0 || (dx == 0 && dy == 0))
            begin
                res.status = acb_pkg::STATUS_DEGENERATE;
                return res;
            end
            status = acb_pkg::STATUS_OK;
            ox = 0;
            oy = 0;
            if (!centre_offset(dx, scaled_b, -dy, one_minus, bq, ox) ||
                !centre_offset(dy, scaled_b, dx, one_minus, bq, oy))
                status = acb_pkg::STATUS_RANGE;
            cx = (status == acb_pkg::STATUS_OK) ? $signed(ax[63:0]) + ox : 64'sd0;
            cy = (status == acb_pkg::STATUS_OK) ? $signed(ay[63:0]) + oy : 64'sd0;
            if (cx < -64'sd2147483648 || cx > 64'sd2147483647 ||
                cy < -64'sd2147483648 || cy > 64'sd2147483647)
                status = acb_pkg::STATUS_RANGE;
            // floor(2r) is the integer root of (D*P^2 >> 34) / B^2.
            dist_sq = dx * dx + dy * dy;
            p_term  = (256'd1 << 32) + bb;
            quo     = ((dist_sq * p_term * p_term) >> 34) / bb;
            root    = 0;
            for (int k = 33; k >= 0; k--)
            begin
                cand = root | (64'd1 << k);
                sq   = {192'd0, cand} * {192'd0, cand};
                if (sq <= quo)
                    root = cand;
            end
            if (root >= (64'd1 << 33) - 1)
                status = acb_pkg::STATUS_RANGE;
            res.status = status;
            if (status == acb_pkg::STATUS_OK)
            begin
                res.centre_x  = cx[31:0];
                res.centre_y  = cy[31:0];
                res.radius_mm = 32'((root + 1) >> 1);
            end
            return res;
        endfunction

        function void note_item(input acb_pkg::arc_in_t chord);
            expected_q.insert(expected_q.size(), predict_arc(chord));
        endfunction

        function void check_result(input acb_pkg::arc_out_t got);
            acb_pkg::arc_out_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %p", got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.status <= acb_pkg::STATUS_RANGE)
                status_seen[want.status]++;
            if (got.status !== want.status || got.centre_x !== want.centre_x ||
                got.centre_y !== want.centre_y || got.radius_mm !== want.radius_mm ||
                got.counter_clockwise !== want.counter_clockwise)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    acb_pkg::arc_in_t  item;
    logic              done;
    acb_pkg::arc_out_t result;

    arc_scoreboard sb;
    int unsigned   idle_cycles = 0;
    int unsigned   items_sent;

    arc_centre_from_bulge i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Monitor: record accepted chord beats and check result beats.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(item);
        if (rst_n && done)
            sb.check_result(result);
        if ((rst_n && start && !busy) || (rst_n && done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog on cycles with no beat in either direction.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one chord beat after a gap, holding start until it is taken.
    task automatic send_chord(input acb_pkg::arc_in_t chord, input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= chord;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_parts(input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] ex, input logic [31:0] ey,
                              input logic [31:0] bulge);
        acb_pkg::arc_in_t chord;
        chord.start_x   = sx;
        chord.start_y   = sy;
        chord.end_x     = ex;
        chord.end_y     = ey;
        chord.bulge_q16 = bulge;
        send_chord(chord, $urandom_range(0, 5));
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 20000)) - 10000);
    endfunction

    function automatic logic [31:0] any_bulge();
        logic [31:0] b;
        case ($urandom_range(0, 3))
            0: b = 32'($signed($urandom_range(1, 131072)));
            1: b = -32'($signed($urandom_range(1, 131072)));
            2: b = 32'($signed($urandom_range(0, 2000))) - 32'd1000;
            default: b = $urandom();
        endcase
        return b;
    endfunction

    // Stimulus.
    initial
    begin
        logic [31:0] sx, sy;
        sb          = new();
        items_sent  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners: degenerate inputs, semicircles, extremes.
        send_parts(0, 0, 100, 0, 32'h0000_0000);
        send_parts(5, 5, 5, 5, 32'h0001_0000);
        send_parts(-7, 3, -7, 3, 32'hFFFF_0000);
        send_parts(0, 0, 100, 0, 32'h0001_0000);
        send_parts(0, 0, 100, 0, 32'hFFFF_0000);
        send_parts(0, 0, 0, 100, 32'h0000_8000);
        send_parts(0, 0, 1, 0, 32'h0000_0001);
        send_parts(0, 0, 1, 0, 32'hFFFF_FFFF);
        send_parts(0, 0, 1, 1, 32'h7FFF_FFFF);
        send_parts(0, 0, 1, 1, 32'h8000_0000);
        send_parts(0, 0, 3, 0, 32'h0001_0000);
        send_parts(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h0001_0000);
        send_parts(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_0000);
        send_parts(32'h7FFF_FFF0, 0, 32'h7FFF_FFFF, 0, 32'h0001_0000);
        send_parts(32'h8000_0000, 0, 32'h8000_0010, 0, 32'hFFFF_0000);
        send_parts(0, 0, 1000, 0, 32'h0000_0010);
        send_parts(-500, 200, 700, -300, 32'h0000_4000);
        send_parts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0002_0000);
        send_parts(0, 0, 32'h7FFF_FFFF, 0, 32'h0000_0001);

        // Random chords; short chords dominate so most arcs resolve.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1:
                    send_parts($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                2:
                begin
                    sx = $urandom();
                    sy = $urandom();
                    send_parts(sx, sy, sx, sy, any_bulge());
                end
                3:
                begin
                    sx = $urandom();
                    sy = $urandom();
                    send_parts(sx, sy, sx + near_coord(), sy + near_coord(), any_bulge());
                end
                default:
                    send_parts(near_coord(), near_coord(), near_coord(), near_coord(),
                               any_bulge());
            endcase
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d chords, checked %0d results.", items_sent, sb.checked);
        $display("Status mix: %0d arcs, %0d degenerate, %0d out of range.",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
